[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the explicit level resolver rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge out of reset
`define BXLR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bxlr assertion failed");
// condition must never be true out of reset
`define BXLR_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bxlr forbidden condition seen");
`else
`define BXLR_ASSERT(name, clk, rst_n, prop)
`define BXLR_NEVER(name, clk, rst_n, cond)
`endif
`endif

[rtl/core/bxlr_pkg.sv]
// ---------------------------------------------------------------------------
// bxlr_pkg
// types, class codes and helpers of the explicit level resolver
// ---------------------------------------------------------------------------
`default_nettype none

package bxlr_pkg;

  localparam int MAX_LEVEL_DEF  = 125;
  localparam int COUNT_BITS_DEF = 16;

  localparam int CLASS_W = 5;
  localparam int LEVEL_W = 7;
  localparam int VI_W    = 7;

  // bidi class codes
  localparam logic [CLASS_W-1:0] CL_L   = 5'd0;
  localparam logic [CLASS_W-1:0] CL_R   = 5'd1;
  localparam logic [CLASS_W-1:0] CL_BN  = 5'd9;
  localparam logic [CLASS_W-1:0] CL_B   = 5'd10;
  localparam logic [CLASS_W-1:0] CL_LRE = 5'd14;
  localparam logic [CLASS_W-1:0] CL_LRO = 5'd15;
  localparam logic [CLASS_W-1:0] CL_RLE = 5'd16;
  localparam logic [CLASS_W-1:0] CL_RLO = 5'd17;
  localparam logic [CLASS_W-1:0] CL_PDF = 5'd18;
  localparam logic [CLASS_W-1:0] CL_LRI = 5'd19;
  localparam logic [CLASS_W-1:0] CL_RLI = 5'd20;
  localparam logic [CLASS_W-1:0] CL_FSI = 5'd21;
  localparam logic [CLASS_W-1:0] CL_PDI = 5'd22;

  // override codes of a stack entry
  localparam logic [1:0] OVR_NONE = 2'd0;
  localparam logic [1:0] OVR_LTR  = 2'd1;
  localparam logic [1:0] OVR_RTL  = 2'd2;

  typedef struct packed {
    logic               iso;
    logic [1:0]         ovr;
    logic [LEVEL_W-1:0] lvl;
  } entry_t;

  typedef struct packed {
    logic exec;   // item accepted, apply its stack update
    logic pop;    // drop the top entry, read the one below
    logic load;   // move read data into the top entry
    logic emit;   // load the output register
  } cmd_t;

  typedef struct packed {
    logic walk;      // accepted pdi closes an isolate
    logic pdf_pop;   // accepted pdf pops one embedding
    logic top_zero;
    logic top_iso;
    logic out_free;
  } status_t;

  function automatic logic [CLASS_W-1:0] apply_ovr(input logic [CLASS_W-1:0] cls,
                                                   input logic [1:0] ovr);
    logic [CLASS_W-1:0] res;
    case (ovr)
      OVR_LTR: res = CL_L;
      OVR_RTL: res = CL_R;
      default: res = cls;
    endcase
    return res;
  endfunction

  // fsi resolves to lri or rli
  function automatic logic [CLASS_W-1:0] eff_class(input logic [CLASS_W-1:0] cls,
                                                   input logic fsi_rtl);
    logic [CLASS_W-1:0] res;
    res = cls;
    if (cls == CL_FSI) begin
      res = fsi_rtl ? CL_RLI : CL_LRI;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/core/bxlr_ctrl.sv]
// ---------------------------------------------------------------------------
// bxlr_ctrl
// sequencer: accept, pop walk over the status stack, result hand-off
// ---------------------------------------------------------------------------
`default_nettype none

module bxlr_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  bxlr_pkg::status_t    st_i,
  output bxlr_pkg::cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_LOAD = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   walk_q, walk_d;
  logic   popped_iso_q, popped_iso_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    walk_d       = walk_q;
    popped_iso_d = popped_iso_q;
    cmd_o        = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          walk_d     = st_i.walk;
          if (st_i.walk || st_i.pdf_pop) begin
            state_d = S_POP;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_POP: begin
        if (st_i.top_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.pop    = 1'b1;
          popped_iso_d = st_i.top_iso;
          state_d      = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        // a pdi walk stops once the isolate entry itself is gone
        if (!walk_q || popped_iso_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_POP;
        end
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      walk_q       <= 1'b0;
      popped_iso_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      walk_q       <= walk_d;
      popped_iso_q <= popped_iso_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bxlr_dp.sv]
// ---------------------------------------------------------------------------
// bxlr_dp
// status stack, counters, cached top entry and output register
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bxlr_dp #(
  parameter int MAX_LEVEL  = bxlr_pkg::MAX_LEVEL_DEF,
  parameter int COUNT_BITS = bxlr_pkg::COUNT_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire [bxlr_pkg::CLASS_W-1:0]       bidi_class_i,
  input  wire                               paragraph_start_i,
  input  wire                               paragraph_level_i,
  input  wire                               fsi_is_rtl_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [bxlr_pkg::LEVEL_W-1:0]      level_o,
  output logic [bxlr_pkg::CLASS_W-1:0]      class_out_o,
  output logic                              removed_o,
  input  bxlr_pkg::cmd_t                    cmd_i,
  output bxlr_pkg::status_t                 st_o
);

  localparam int DEPTH = MAX_LEVEL + 2;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int LW    = bxlr_pkg::LEVEL_W;
  localparam int CW    = bxlr_pkg::CLASS_W;
  localparam int VW    = bxlr_pkg::VI_W;

  bxlr_pkg::entry_t stack_mem [DEPTH];
  bxlr_pkg::entry_t rdata_q;

  // top entry kept in flops, bottom level kept apart from the memory
  bxlr_pkg::entry_t        top_q, top_d;
  logic [IDX_W-1:0]        sp_q, sp_d;
  logic [LW-1:0]           bottom_q, bottom_d;
  logic [COUNT_BITS-1:0]   ovi_q, ovi_d;
  logic [COUNT_BITS-1:0]   ove_q, ove_d;
  logic [VW-1:0]           vi_q, vi_d;

  logic [CW-1:0]           item_cls_q;
  logic                    item_fsi_q;
  logic [LW-1:0]           iso_lvl_q;
  logic [CW-1:0]           iso_cls_q;

  logic                    out_valid_q;
  logic [LW-1:0]           out_lvl_q;
  logic [CW-1:0]           out_cls_q;
  logic                    out_rm_q;

  // state seen by the accepted item, after a paragraph restart
  bxlr_pkg::entry_t        top_e;
  logic [IDX_W-1:0]        sp_e;
  logic [LW-1:0]           bottom_e;
  logic [COUNT_BITS-1:0]   ovi_e, ove_e;
  logic [VW-1:0]           vi_e;

  logic [CW-1:0]           cls_e;
  logic                    is_emb, is_iso, is_rtl;
  logic [1:0]              ovr_new;
  logic [LW:0]             nl;
  logic                    push_ok;
  logic                    pdi_walk, pdf_pop;
  bxlr_pkg::entry_t        new_ent;
  logic [IDX_W-1:0]        wr_addr;
  logic [IDX_W-1:0]        rd_addr;
  logic                    wr_en;

  logic [CW-1:0]           res_cls_e;
  logic [LW-1:0]           res_lvl;
  logic [CW-1:0]           res_cls;
  logic                    res_rm;

  always_comb begin
    if (paragraph_start_i) begin
      top_e    = '{iso: 1'b0, ovr: bxlr_pkg::OVR_NONE, lvl: LW'(paragraph_level_i)};
      sp_e     = '0;
      bottom_e = LW'(paragraph_level_i);
      ovi_e    = '0;
      ove_e    = '0;
      vi_e     = '0;
    end else begin
      top_e    = top_q;
      sp_e     = sp_q;
      bottom_e = bottom_q;
      ovi_e    = ovi_q;
      ove_e    = ove_q;
      vi_e     = vi_q;
    end
  end

  assign cls_e  = bxlr_pkg::eff_class(bidi_class_i, fsi_is_rtl_i);
  assign is_emb = (cls_e == bxlr_pkg::CL_LRE) || (cls_e == bxlr_pkg::CL_LRO) ||
                  (cls_e == bxlr_pkg::CL_RLE) || (cls_e == bxlr_pkg::CL_RLO);
  assign is_iso = (cls_e == bxlr_pkg::CL_LRI) || (cls_e == bxlr_pkg::CL_RLI);
  assign is_rtl = (cls_e == bxlr_pkg::CL_RLE) || (cls_e == bxlr_pkg::CL_RLO) ||
                  (cls_e == bxlr_pkg::CL_RLI);

  always_comb begin
    if (cls_e == bxlr_pkg::CL_RLO) begin
      ovr_new = bxlr_pkg::OVR_RTL;
    end else if (cls_e == bxlr_pkg::CL_LRO) begin
      ovr_new = bxlr_pkg::OVR_LTR;
    end else begin
      ovr_new = bxlr_pkg::OVR_NONE;
    end
  end

  // next odd level for rtl, next even level for ltr
  always_comb begin
    if (is_rtl) begin
      nl = ({1'b0, top_e.lvl} + (LW+1)'(1)) | (LW+1)'(1);
    end else begin
      nl = ({1'b0, top_e.lvl} + (LW+1)'(2)) & ~(LW+1)'(1);
    end
  end

  assign push_ok = (is_emb || is_iso) && (nl <= (LW+1)'(MAX_LEVEL)) &&
                   (ovi_e == '0) && (ove_e == '0) &&
                   ((IDX_W+1)'(sp_e) + (IDX_W+1)'(1) < (IDX_W+1)'(DEPTH));
  assign new_ent = '{iso: is_iso, ovr: ovr_new, lvl: nl[LW-1:0]};
  assign wr_addr = sp_e + IDX_W'(1);
  assign rd_addr = sp_q - IDX_W'(1);
  assign wr_en   = cmd_i.exec && push_ok;

  assign pdi_walk = (cls_e == bxlr_pkg::CL_PDI) && (ovi_e == '0) && (vi_e != '0);
  assign pdf_pop  = (cls_e == bxlr_pkg::CL_PDF) && (ovi_e == '0) && (ove_e == '0) &&
                    (sp_e != '0) && !top_e.iso;

  always_comb begin
    top_d    = top_q;
    sp_d     = sp_q;
    bottom_d = bottom_q;
    ovi_d    = ovi_q;
    ove_d    = ove_q;
    vi_d     = vi_q;
    if (cmd_i.exec) begin
      top_d    = top_e;
      sp_d     = sp_e;
      bottom_d = bottom_e;
      ovi_d    = ovi_e;
      ove_d    = ove_e;
      vi_d     = vi_e;
      if (push_ok) begin
        top_d = new_ent;
        sp_d  = wr_addr;
        if (is_iso && (vi_e != '1)) begin
          vi_d = vi_e + VW'(1);
        end
      end else if (is_emb) begin
        if ((ovi_e == '0) && (ove_e != '1)) begin
          ove_d = ove_e + COUNT_BITS'(1);
        end
      end else if (is_iso) begin
        if (ovi_e != '1) begin
          ovi_d = ovi_e + COUNT_BITS'(1);
        end
      end else if (cls_e == bxlr_pkg::CL_PDI) begin
        if (ovi_e != '0) begin
          if (ovi_e != '1) begin
            ovi_d = ovi_e - COUNT_BITS'(1);
          end
        end else if (vi_e != '0) begin
          ove_d = '0;
          vi_d  = vi_e - VW'(1);
        end
      end else if (cls_e == bxlr_pkg::CL_PDF) begin
        if ((ovi_e == '0) && (ove_e != '0) && (ove_e != '1)) begin
          ove_d = ove_e - COUNT_BITS'(1);
        end
      end
    end
    if (cmd_i.pop) begin
      sp_d = rd_addr;
    end
    if (cmd_i.load) begin
      if (sp_q == '0) begin
        top_d = '{iso: 1'b0, ovr: bxlr_pkg::OVR_NONE, lvl: bottom_q};
      end else begin
        top_d = rdata_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= new_ent;
    end
    if (cmd_i.pop) begin
      rdata_q <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= '0;
      sp_q     <= '0;
      bottom_q <= '0;
      ovi_q    <= '0;
      ove_q    <= '0;
      vi_q     <= '0;
    end else begin
      top_q    <= top_d;
      sp_q     <= sp_d;
      bottom_q <= bottom_d;
      ovi_q    <= ovi_d;
      ove_q    <= ove_d;
      vi_q     <= vi_d;
    end
  end

  // isolate initiators report the entry below their own push
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      item_cls_q <= bidi_class_i;
      item_fsi_q <= fsi_is_rtl_i;
      iso_lvl_q  <= top_e.lvl;
      iso_cls_q  <= bxlr_pkg::apply_ovr(bidi_class_i, top_e.ovr);
    end
  end

  assign res_cls_e = bxlr_pkg::eff_class(item_cls_q, item_fsi_q);

  always_comb begin
    res_lvl = top_q.lvl;
    res_cls = item_cls_q;
    res_rm  = 1'b0;
    if (item_cls_q inside {bxlr_pkg::CL_LRE, bxlr_pkg::CL_LRO, bxlr_pkg::CL_RLE,
                           bxlr_pkg::CL_RLO, bxlr_pkg::CL_PDF, bxlr_pkg::CL_BN}) begin
      res_rm = 1'b1;
    end else if (res_cls_e inside {bxlr_pkg::CL_LRI, bxlr_pkg::CL_RLI}) begin
      res_lvl = iso_lvl_q;
      res_cls = iso_cls_q;
    end else if (item_cls_q == bxlr_pkg::CL_B) begin
      res_lvl = bottom_q;
    end else begin
      res_cls = bxlr_pkg::apply_ovr(item_cls_q, top_q.ovr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_lvl_q <= res_lvl;
      out_cls_q <= res_cls;
      out_rm_q  <= res_rm;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = out_lvl_q;
  assign class_out_o = out_cls_q;
  assign removed_o   = out_rm_q;

  assign st_o.walk     = pdi_walk;
  assign st_o.pdf_pop  = pdf_pop;
  assign st_o.top_zero = (sp_q == '0);
  assign st_o.top_iso  = top_q.iso;
  assign st_o.out_free = !out_valid_q || out_ready_i;

  `BXLR_NEVER(a_level_range, clk_i, rst_ni, top_q.lvl > LW'(MAX_LEVEL))
  `BXLR_NEVER(a_iso_count, clk_i, rst_ni, (IDX_W+VW)'(vi_q) > (IDX_W+VW)'(sp_q))
  `BXLR_NEVER(a_pop_bottom, clk_i, rst_ni, cmd_i.pop && (sp_q == '0))
  `BXLR_ASSERT(a_emit_free, clk_i, rst_ni, cmd_i.emit |-> (!out_valid_q || out_ready_i))

endmodule

`default_nettype wire

[rtl/core/bidi_explicit_level_resolver.sv]
// ---------------------------------------------------------------------------
// bidi_explicit_level_resolver
// explicit embedding levels (bidi rules x1 to x9), one character per item
// ---------------------------------------------------------------------------
// Takes one bidi class per item and returns its explicit level, its class
// after directional override and the x9 removed flag. Paragraph level and
// fsi direction come in with the item. Most items go from accept (S_IDLE) to
// the result load (S_DONE). A pdf that pops an embedding passes through S_POP
// and S_LOAD first. A pdi that closes an isolate runs S_POP and S_LOAD once per
// stack entry popped, since the stack memory has one registered read port and
// the walk reads one entry per pop. The output register lets the next item be
// accepted while a result still waits; a held output stalls the finish.
`default_nettype none

module bidi_explicit_level_resolver #(
  parameter int MAX_LEVEL  = bxlr_pkg::MAX_LEVEL_DEF,
  parameter int COUNT_BITS = bxlr_pkg::COUNT_BITS_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire [bxlr_pkg::CLASS_W-1:0]   bidi_class_i,
  input  wire                           paragraph_start_i,
  input  wire                           paragraph_level_i,
  input  wire                           fsi_is_rtl_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [bxlr_pkg::LEVEL_W-1:0]  level_o,
  output logic [bxlr_pkg::CLASS_W-1:0]  class_out_o,
  output logic                          removed_o
);

  bxlr_pkg::cmd_t    cmd;
  bxlr_pkg::status_t st;

  bxlr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  bxlr_dp #(
    .MAX_LEVEL  (MAX_LEVEL),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .bidi_class_i      (bidi_class_i),
    .paragraph_start_i (paragraph_start_i),
    .paragraph_level_i (paragraph_level_i),
    .fsi_is_rtl_i      (fsi_is_rtl_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .level_o           (level_o),
    .class_out_o       (class_out_o),
    .removed_o         (removed_o),
    .cmd_i             (cmd),
    .st_o              (st)
  );

endmodule

`default_nettype wire
